>>> hdl/gsps_pkg.sv
package gsps_pkg;

    localparam int unsigned GainW    = 16;
    localparam int unsigned SpeedW   = 15;
    localparam int unsigned TargetW  = 16;
    localparam int unsigned MagW     = 16;
    localparam int unsigned ErrW     = 17;
    localparam int unsigned SumW     = 16;
    localparam int unsigned SumRawW  = 18;
    localparam int unsigned DeW      = 18;
    localparam int unsigned ProdPW   = 34;
    localparam int unsigned ProdIW   = 33;
    localparam int unsigned ProdDW   = 35;
    localparam int unsigned AccW     = 37;
    localparam int unsigned FracW    = 16;
    localparam int unsigned LevelW   = 8;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 48;

    localparam logic [CfgIdxW-1:0] CFG_GAINS_FWD_HIGH = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_GAINS_FWD_LOW  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_GAINS_REV_HIGH = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_GAINS_REV_LOW  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_THRESHOLD      = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_INT_LIMIT      = 3'd5;

    localparam logic [SpeedW-1:0] THRESHOLD_RST = 15'd2400;
    localparam logic [SpeedW-1:0] LIMIT_RST     = 15'd16000;

    typedef struct packed {
        logic [GainW-1:0] kp;
        logic [GainW-1:0] ki;
        logic [GainW-1:0] kd;
    } t_gains;

endpackage

>>> hdl/gsps_cfg.sv
module gsps_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_write,
    input  logic [gsps_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [gsps_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                           i_reverse,
    input  logic [gsps_pkg::MagW-1:0]      i_mag,
    output gsps_pkg::t_gains               o_gains,
    output logic [gsps_pkg::SpeedW-1:0]    o_limit
);
    import gsps_pkg::*;

    t_gains              r_gains_fwd_high;
    t_gains              r_gains_fwd_low;
    t_gains              r_gains_rev_high;
    t_gains              r_gains_rev_low;
    logic [SpeedW-1:0]   r_threshold;
    logic [SpeedW-1:0]   r_limit;
    logic                high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains_fwd_high <= '0;
            r_gains_fwd_low  <= '0;
            r_gains_rev_high <= '0;
            r_gains_rev_low  <= '0;
            r_threshold      <= THRESHOLD_RST;
            r_limit          <= LIMIT_RST;
        end else if (i_cfg_write) begin
            case (i_cfg_index)
                CFG_GAINS_FWD_HIGH: r_gains_fwd_high <= t_gains'(i_cfg_data);
                CFG_GAINS_FWD_LOW:  r_gains_fwd_low  <= t_gains'(i_cfg_data);
                CFG_GAINS_REV_HIGH: r_gains_rev_high <= t_gains'(i_cfg_data);
                CFG_GAINS_REV_LOW:  r_gains_rev_low  <= t_gains'(i_cfg_data);
                CFG_THRESHOLD:      r_threshold      <= i_cfg_data[SpeedW-1:0];
                CFG_INT_LIMIT:      r_limit          <= i_cfg_data[SpeedW-1:0];
                default: ;
            endcase
        end
    end

    assign high = (i_mag >= {1'b0, r_threshold});

    always_comb begin
        case ({i_reverse, high})
            2'b00:   o_gains = r_gains_fwd_low;
            2'b01:   o_gains = r_gains_fwd_high;
            2'b10:   o_gains = r_gains_rev_low;
            default: o_gains = r_gains_rev_high;
        endcase
    end

    assign o_limit = r_limit;

endmodule

>>> hdl/gsps_err.sv
module gsps_err (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic [gsps_pkg::MagW-1:0]           i_mag,
    input  logic [gsps_pkg::SpeedW-1:0]         i_meas,
    input  logic [gsps_pkg::SpeedW-1:0]         i_limit,
    output logic signed [gsps_pkg::ErrW-1:0]    o_err,
    output logic signed [gsps_pkg::SumW-1:0]    o_sum,
    output logic signed [gsps_pkg::DeW-1:0]     o_de
);
    import gsps_pkg::*;

    logic signed [SumW-1:0]    r_error_sum;
    logic signed [ErrW-1:0]    r_previous_error;
    logic signed [ErrW-1:0]    err;
    logic signed [SumRawW-1:0] raw_sum;
    logic signed [SumRawW-1:0] lim_s;
    logic signed [SumRawW-1:0] sum_c;

    assign err     = $signed({1'b0, i_mag}) - $signed({2'b00, i_meas});
    assign raw_sum = SumRawW'(r_error_sum) + SumRawW'(err);
    assign lim_s   = $signed({3'b000, i_limit});

    always_comb begin
        if (raw_sum > lim_s) begin
            sum_c = lim_s;
        end else if (raw_sum < -lim_s) begin
            sum_c = -lim_s;
        end else begin
            sum_c = raw_sum;
        end
    end

    assign o_err = err;
    assign o_sum = sum_c[SumW-1:0];
    assign o_de  = DeW'(err) - DeW'(r_previous_error);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum      <= '0;
            r_previous_error <= '0;
        end else if (i_load) begin
            r_error_sum      <= sum_c[SumW-1:0];
            r_previous_error <= err;
        end
    end

endmodule

>>> hdl/gsps_mac.sv
module gsps_mac (
    input  logic                               i_clk,
    input  logic                               i_load,
    input  gsps_pkg::t_gains                   i_gains,
    input  logic signed [gsps_pkg::ErrW-1:0]   i_err,
    input  logic signed [gsps_pkg::SumW-1:0]   i_sum,
    input  logic signed [gsps_pkg::DeW-1:0]    i_de,
    output logic [gsps_pkg::LevelW-1:0]        o_level
);
    import gsps_pkg::*;

    logic signed [GainW:0]    kp_s;
    logic signed [GainW:0]    ki_s;
    logic signed [GainW:0]    kd_s;
    logic signed [ProdPW-1:0] r_prod_p;
    logic signed [ProdIW-1:0] r_prod_i;
    logic signed [ProdDW-1:0] r_prod_d;
    logic signed [AccW-1:0]   acc;

    assign kp_s = $signed({1'b0, i_gains.kp});
    assign ki_s = $signed({1'b0, i_gains.ki});
    assign kd_s = $signed({1'b0, i_gains.kd});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod_p <= ProdPW'(kp_s) * ProdPW'(i_err);
            r_prod_i <= ProdIW'(ki_s) * ProdIW'(i_sum);
            r_prod_d <= ProdDW'(kd_s) * ProdDW'(i_de);
        end
    end

    assign acc = AccW'(r_prod_p) + AccW'(r_prod_i) + AccW'(r_prod_d);

    always_comb begin
        if (acc[AccW-1]) begin
            o_level = '0;
        end else if (|acc[AccW-2:FracW+LevelW]) begin
            o_level = '1;
        end else begin
            o_level = acc[FracW+LevelW-1:FracW];
        end
    end

endmodule

>>> hdl/gain_scheduled_pid_speed.sv
// Gain-scheduled PID speed controller with integral clamp.
//
// Input channel: i_in_valid / o_in_stall carry one control tick item
// (i_target_speed signed, i_measured_speed unsigned, both 1/16 rpm).
// Output channel: o_out_valid / i_out_stall carry one result item
// (o_drive_level 0..255, o_reverse_dir). A zero setpoint is taken and
// dropped: it gives no result and leaves the controller state alone.
// Configuration: i_cfg_valid with i_cfg_index / i_cfg_data; o_cfg_ready is
// always high. Write only while no item is in flight.
//
// Throughput: one item per cycle while the output is not stalled. A result
// passes through the input, error, product and output registers in turn.
// The error sum and previous error update as an item enters the error
// registers, so the next item behind it sees the updated values.
// Reset clears all stages and state, gains to zero, threshold to 2400 and
// integral limit to 16000. A stalled result holds; earlier stages keep
// filling behind it, and o_in_stall rises only when every stage is full.
module gain_scheduled_pid_speed (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [gsps_pkg::TargetW-1:0]  i_target_speed,
    input  logic [gsps_pkg::SpeedW-1:0]          i_measured_speed,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [gsps_pkg::LevelW-1:0]          o_drive_level,
    output logic                                 o_reverse_dir,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [gsps_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  logic [gsps_pkg::CfgDataW-1:0]        i_cfg_data
);
    import gsps_pkg::*;

    logic                    r_v1;
    logic [MagW-1:0]         r_mag;
    logic [SpeedW-1:0]       r_meas;
    logic                    r_rev1;

    logic                    r_v2;
    logic                    r_rev2;
    t_gains                  r_gains;
    logic signed [ErrW-1:0]  r_err;
    logic signed [SumW-1:0]  r_sum;
    logic signed [DeW-1:0]   r_de;

    logic                    r_v3;
    logic                    r_rev3;

    logic                    r_v4;
    logic                    r_rev4;
    logic [LevelW-1:0]       r_level;

    logic                    free1, free2, free3, free4;
    logic                    mv1, mv2, mv3;
    logic                    in_acc;
    logic [MagW-1:0]         n_mag;
    t_gains                  gains;
    logic [SpeedW-1:0]       limit;
    logic signed [ErrW-1:0]  err;
    logic signed [SumW-1:0]  sum;
    logic signed [DeW-1:0]   de;
    logic [LevelW-1:0]       level;

    assign free4 = !r_v4 || !i_out_stall;
    assign mv3   = r_v3 && free4;
    assign free3 = !r_v3 || mv3;
    assign mv2   = r_v2 && free3;
    assign free2 = !r_v2 || mv2;
    assign mv1   = r_v1 && free2;
    assign free1 = !r_v1 || mv1;

    assign o_in_stall  = !free1;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && free1;

    assign n_mag = i_target_speed[TargetW-1] ? MagW'(-i_target_speed)
                                             : MagW'(i_target_speed);

    gsps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_write (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_reverse   (r_rev1),
        .i_mag       (r_mag),
        .o_gains     (gains),
        .o_limit     (limit)
    );

    gsps_err u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (mv1),
        .i_mag   (r_mag),
        .i_meas  (r_meas),
        .i_limit (limit),
        .o_err   (err),
        .o_sum   (sum),
        .o_de    (de)
    );

    gsps_mac u_mac (
        .i_clk   (i_clk),
        .i_load  (mv2),
        .i_gains (r_gains),
        .i_err   (r_err),
        .i_sum   (r_sum),
        .i_de    (r_de),
        .o_level (level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (free1) begin
                r_v1 <= i_in_valid && (i_target_speed != '0);
            end
            if (free2) begin
                r_v2 <= r_v1;
            end
            if (free3) begin
                r_v3 <= r_v2;
            end
            if (free4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mag  <= n_mag;
            r_meas <= i_measured_speed;
            r_rev1 <= i_target_speed[TargetW-1];
        end
        if (mv1) begin
            r_gains <= gains;
            r_err   <= err;
            r_sum   <= sum;
            r_de    <= de;
            r_rev2  <= r_rev1;
        end
        if (mv2) begin
            r_rev3 <= r_rev2;
        end
        if (mv3) begin
            r_level <= level;
            r_rev4  <= r_rev3;
        end
    end

    assign o_out_valid   = r_v4;
    assign o_drive_level = r_level;
    assign o_reverse_dir = r_rev4;

    a_zero_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_target_speed == '0)) |=> !r_v1)
        else $error("zero setpoint entered the pipeline");

    a_sum_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> ((r_sum <= $signed({1'b0, limit})) && (r_sum >= -$signed({1'b0, limit}))))
        else $error("integral sum outside clamp");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3 && r_v4))
        else $error("input stalled with an empty stage");

    a_hold_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !free2) |=> (r_v1 && $stable(r_mag) && $stable(r_meas)))
        else $error("blocked item in first stage changed");

endmodule
